/* src/terminal_key_sequence_decoder_core_defines.svh */
// Shared assertion macros. Modules using them need clk and rst in scope.
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_CORE_DEFINES_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define TKSD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("tksd: invariant violated");

// Antecedent at one edge implies consequent at the next edge.
`define TKSD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tksd: next-cycle check failed");

`endif

/* src/tksd_pkg.sv */
package tksd_pkg;

  // event kinds
  localparam logic [1:0] KIND_KEY  = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_UNK  = 2'd2;
  localparam logic [1:0] KIND_INC  = 2'd3;

  // key codes
  localparam logic [4:0] KEY_UP     = 5'd0;
  localparam logic [4:0] KEY_DOWN   = 5'd1;
  localparam logic [4:0] KEY_RIGHT  = 5'd2;
  localparam logic [4:0] KEY_LEFT   = 5'd3;
  localparam logic [4:0] KEY_HOME   = 5'd4;
  localparam logic [4:0] KEY_END    = 5'd5;
  localparam logic [4:0] KEY_INSERT = 5'd6;
  localparam logic [4:0] KEY_DELETE = 5'd7;
  localparam logic [4:0] KEY_PGUP   = 5'd8;
  localparam logic [4:0] KEY_PGDN   = 5'd9;
  localparam logic [4:0] KEY_F1     = 5'd10;
  localparam logic [4:0] KEY_TAB    = 5'd22;
  localparam logic [4:0] KEY_BKSP   = 5'd23;
  localparam logic [4:0] KEY_ENTER  = 5'd24;
  localparam logic [4:0] KEY_ESCAPE = 5'd25;
  localparam logic [4:0] KEY_NONE   = 5'd31;  // no mapping

  // byte values
  localparam logic [7:0] BYTE_ESC   = 8'h1b;
  localparam logic [7:0] BYTE_TAB   = 8'h09;
  localparam logic [7:0] BYTE_DEL   = 8'h7f;
  localparam logic [7:0] BYTE_CR    = 8'h0d;
  localparam logic [7:0] BYTE_LBR   = 8'h5b;
  localparam logic [7:0] BYTE_SS3   = 8'h4f;
  localparam logic [7:0] BYTE_TILDE = 8'h7e;
  localparam logic [7:0] BYTE_SEMI  = 8'h3b;

  localparam logic [2:0] MOD_NONE = 3'd0;
  localparam logic [2:0] MOD_CTRL = 3'd4;

  localparam int TKSD_QUEUE_DEPTH = 4;

  // one classified input beat
  typedef struct packed {
    logic       last;
    logic       is_esc;
    logic       is_lbr;
    logic       is_ss3;
    logic       is_tilde;
    logic       is_semi;
    logic       is_digit;
    logic       is_letter;
    logic [3:0] digit;
    logic [4:0] letter_code;
    logic [1:0] bkind;   // event if seen in begin state
    logic [4:0] bkey;
    logic [7:0] bchar;
    logic [2:0] bmod;
  } tksd_cls_t;

endpackage

/* src/tksd_front.sv */
module tksd_front
  import tksd_pkg::*;
(
  input  logic [7:0] in_byte,
  input  logic       last_in_read,
  output tksd_cls_t  cls
);

  function automatic logic [4:0] code_by_letter(input logic [7:0] c);
    case (c)
      8'h41:   code_by_letter = KEY_UP;
      8'h42:   code_by_letter = KEY_DOWN;
      8'h43:   code_by_letter = KEY_RIGHT;
      8'h44:   code_by_letter = KEY_LEFT;
      8'h48:   code_by_letter = KEY_HOME;
      8'h46:   code_by_letter = KEY_END;
      8'h50:   code_by_letter = KEY_F1;
      8'h51:   code_by_letter = KEY_F1 + 5'd1;
      8'h52:   code_by_letter = KEY_F1 + 5'd2;
      8'h53:   code_by_letter = KEY_F1 + 5'd3;
      default: code_by_letter = KEY_NONE;
    endcase
  endfunction

  logic [7:0] ctrl_ch;

  always_comb begin
    cls.last        = last_in_read;
    cls.is_esc      = (in_byte == BYTE_ESC);
    cls.is_lbr      = (in_byte == BYTE_LBR);
    cls.is_ss3      = (in_byte == BYTE_SS3);
    cls.is_tilde    = (in_byte == BYTE_TILDE);
    cls.is_semi     = (in_byte == BYTE_SEMI);
    cls.is_digit    = (in_byte >= 8'h30) && (in_byte <= 8'h39);
    cls.is_letter   = ((in_byte >= 8'h41) && (in_byte <= 8'h5a)) ||
                      ((in_byte >= 8'h61) && (in_byte <= 8'h7a));
    cls.digit       = in_byte[3:0];
    cls.letter_code = code_by_letter(in_byte);

    // ctrl-letter: fold into lower case
    ctrl_ch = in_byte | 8'h40;
    if ((ctrl_ch >= 8'h41) && (ctrl_ch <= 8'h5a)) begin
      ctrl_ch = ctrl_ch + 8'h20;
    end

    cls.bkey  = KEY_UP;
    cls.bchar = 8'h00;
    cls.bmod  = MOD_NONE;
    if (in_byte == BYTE_TAB) begin
      cls.bkind = KIND_KEY;
      cls.bkey  = KEY_TAB;
    end else if (in_byte == BYTE_DEL) begin
      cls.bkind = KIND_KEY;
      cls.bkey  = KEY_BKSP;
    end else if (in_byte == BYTE_CR) begin
      cls.bkind = KIND_KEY;
      cls.bkey  = KEY_ENTER;
    end else if ((in_byte <= 8'h1f) && (in_byte != 8'h00)) begin
      cls.bkind = KIND_CHAR;
      cls.bchar = ctrl_ch;
      cls.bmod  = MOD_CTRL;
    end else begin
      cls.bkind = KIND_CHAR;
      cls.bchar = in_byte;
    end
  end

endmodule

/* src/tksd_queue.sv */
`include "terminal_key_sequence_decoder_core_defines.svh"

module tksd_queue
  import tksd_pkg::*;
#(
  parameter int DEPTH = TKSD_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr,
  input  tksd_cls_t wr_data,
  output logic      full,
  input  logic      rd,
  output tksd_cls_t rd_data,
  output logic      empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tksd_cls_t     mem [DEPTH];
  logic [AW-1:0] wptr;
  logic [AW-1:0] rptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr && !full;
  assign do_rd   = rd && !empty;
  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + AW'(1);
      end
      if (do_rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  `TKSD_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH))
  `TKSD_ASSERT_NEXT(a_count_up, do_wr && !do_rd, count == $past(count) + CW'(1))
  `TKSD_ASSERT_NEXT(a_count_dn, do_rd && !do_wr, count == $past(count) - CW'(1))

endmodule

/* src/tksd_back.sv */
`include "terminal_key_sequence_decoder_core_defines.svh"

module tksd_back
  import tksd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tksd_cls_t  item,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_kind,
  output logic [4:0] key_code,
  output logic [7:0] char_value,
  output logic [2:0] modifier_mask
);

  typedef enum logic [2:0] {
    ST_BEGIN,
    ST_ESC,
    ST_CSI,
    ST_SS3,
    ST_MOD
  } state_t;

  function automatic logic [4:0] code_by_number(input logic [7:0] n);
    case (n)
      8'd2:    code_by_number = KEY_INSERT;
      8'd3:    code_by_number = KEY_DELETE;
      8'd5:    code_by_number = KEY_PGUP;
      8'd6:    code_by_number = KEY_PGDN;
      8'd15:   code_by_number = KEY_F1 + 5'd4;
      8'd17:   code_by_number = KEY_F1 + 5'd5;
      8'd18:   code_by_number = KEY_F1 + 5'd6;
      8'd19:   code_by_number = KEY_F1 + 5'd7;
      8'd20:   code_by_number = KEY_F1 + 5'd8;
      8'd21:   code_by_number = KEY_F1 + 5'd9;
      8'd23:   code_by_number = KEY_F1 + 5'd10;
      8'd24:   code_by_number = KEY_F1 + 5'd11;
      default: code_by_number = KEY_NONE;
    endcase
  endfunction

  state_t     state;
  state_t     state_next;
  logic [7:0] accum;
  logic [7:0] accum_next;
  logic [3:0] mdig;
  logic [3:0] mdig_next;
  logic       out_valid;

  logic        take;
  logic        emit;
  logic [1:0]  ev_kind;
  logic [4:0]  ev_key;
  logic [7:0]  ev_char;
  logic [2:0]  ev_mod;
  logic [2:0]  mask;
  logic [4:0]  code;
  logic [11:0] acc_sum;

  assign take  = !q_empty && (!out_valid || pop);
  assign q_pop = take;
  assign empty = !out_valid;

  assign mask    = ((mdig >= 4'd2) && (mdig <= 4'd8)) ? 3'(mdig - 4'd1) : MOD_NONE;
  assign acc_sum = ({4'd0, accum} << 3) + ({4'd0, accum} << 1) + {8'd0, item.digit};
  assign code    = item.is_tilde ? code_by_number(accum) : item.letter_code;

  always_comb begin
    state_next = state;
    accum_next = accum;
    mdig_next  = mdig;
    emit       = 1'b0;
    ev_kind    = KIND_KEY;
    ev_key     = KEY_UP;
    ev_char    = 8'h00;
    ev_mod     = MOD_NONE;

    case (state)
      ST_ESC: begin
        if (item.is_lbr) begin
          state_next = ST_CSI;
        end else if (item.is_ss3) begin
          state_next = ST_SS3;
        end
      end
      ST_CSI: begin
        if (item.is_tilde || item.is_letter) begin
          emit       = 1'b1;
          state_next = ST_BEGIN;
        end else if (item.is_semi) begin
          state_next = ST_MOD;
        end else if (item.is_digit) begin
          accum_next = (acc_sum > 12'd255) ? 8'hff : acc_sum[7:0];
        end
      end
      ST_SS3: begin
        emit       = 1'b1;
        state_next = ST_BEGIN;
      end
      ST_MOD: begin
        if (item.is_digit) begin
          mdig_next  = item.digit;
          state_next = ST_CSI;
        end
      end
      default: begin
        state_next = ST_BEGIN;
        accum_next = '0;
        mdig_next  = '0;
        if (item.is_esc) begin
          state_next = ST_ESC;
        end else begin
          emit    = 1'b1;
          ev_kind = item.bkind;
          ev_key  = item.bkey;
          ev_char = item.bchar;
          ev_mod  = item.bmod;
        end
      end
    endcase

    // key lookup result for csi / ss3 terminators
    if (emit && ((state == ST_CSI) || (state == ST_SS3))) begin
      ev_mod = mask;
      if (code == KEY_NONE) begin
        ev_kind = KIND_UNK;
      end else begin
        ev_key = code;
      end
    end

    // end of read burst flushes the parser
    if (item.last) begin
      if (state_next == ST_ESC) begin
        emit    = 1'b1;
        ev_kind = KIND_KEY;
        ev_key  = KEY_ESCAPE;
        ev_char = 8'h00;
        ev_mod  = MOD_NONE;
      end else if (state_next != ST_BEGIN) begin
        emit    = 1'b1;
        ev_kind = KIND_INC;
        ev_key  = KEY_UP;
        ev_char = 8'h00;
        ev_mod  = MOD_NONE;
      end
      state_next = ST_BEGIN;
      accum_next = '0;
      mdig_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BEGIN;
      accum     <= '0;
      mdig      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (take) begin
        state <= state_next;
        accum <= accum_next;
        mdig  <= mdig_next;
        if (emit) begin
          event_kind    <= ev_kind;
          key_code      <= ev_key;
          char_value    <= ev_char;
          modifier_mask <= ev_mod;
        end
      end
      if (take && emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TKSD_ASSERT_NEXT(a_burst_end, take && item.last, state == ST_BEGIN && accum == 8'd0)

endmodule

/* src/terminal_key_sequence_decoder_core.sv */
// A pushed byte is written into the queue, then taken by the parser into the result register (empty low).
// Throughput: one byte per cycle while the result register is free or being popped, set by the parser update.
// Bytes that end no key make no result beat, unless they end a read burst mid-sequence.
// Reset (rst, synchronous, active high): queue emptied, parser back to its begin
// state with number and modifier cleared, result register empty; no clearing pass.
module terminal_key_sequence_decoder_core
  import tksd_pkg::*;
#(
  parameter int QUEUE_DEPTH = TKSD_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  // input side: queue-style write
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       last_in_read,
  // result side: queue-style read
  output logic       empty,
  input  logic       pop,
  output logic [1:0] event_kind,
  output logic [4:0] key_code,
  output logic [7:0] char_value,
  output logic [2:0] modifier_mask
);

  // Front end: stateless byte classifier. Works out every property of the
  // byte the parser may need, plus the event the byte gives in begin state.
  tksd_cls_t cls_in;
  tksd_cls_t cls_out;
  logic      q_empty;
  logic      q_pop;

  tksd_front u_front (
    .in_byte      (in_byte),
    .last_in_read (last_in_read),
    .cls          (cls_in)
  );

  // Short queue between the classifier and the parser; full is the
  // input-side backpressure, so a stalled result blocks accepting only
  // once the queue has filled.
  tksd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (push),
    .wr_data (cls_in),
    .full    (full),
    .rd      (q_pop),
    .rd_data (cls_out),
    .empty   (q_empty)
  );

  // Back end: escape-sequence state machine with the number accumulator and
  // modifier digit, and the result register. It pulls a beat whenever the
  // result register is free or is being popped in the same cycle.
  tksd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (cls_out),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .event_kind    (event_kind),
    .key_code      (key_code),
    .char_value    (char_value),
    .modifier_mask (modifier_mask)
  );

endmodule
